FILE: rtl/particle_pair_match_score_defines.svh
`ifndef PARTICLE_PAIR_MATCH_SCORE_DEFINES_SVH
`define PARTICLE_PAIR_MATCH_SCORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PPMS_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PPMS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/ppms_pkg.sv
`default_nettype none

package ppms_pkg;

    localparam int unsigned TRIG_ENTRIES_DEF = 1024;
    localparam int unsigned FIELD_W          = 16;
    localparam int unsigned COST_W           = 24;
    localparam int unsigned CFG_IDX_W        = 3;
    localparam int unsigned CFG_DATA_W       = 24;
    localparam int unsigned TRIG_W           = 18;
    localparam int unsigned SINE_LAT         = 6;
    localparam int unsigned QUO_W            = 24;

    localparam logic [COST_W-1:0] COST_MAX = '1;

    localparam logic [FIELD_W-1:0] PAR_W_RST  = 16'd2560;
    localparam logic [FIELD_W-1:0] ORTH_W_RST = 16'd12800;
    localparam logic [FIELD_W-1:0] HEAD_W_RST = 16'd256;
    localparam logic [FIELD_W-1:0] AREA_W_RST = 16'd256;
    localparam logic [FIELD_W-1:0] SIZE_RST   = 16'd512;
    localparam logic [COST_W-1:0]  THR_RST    = 24'd65536;

    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [16:0] SIN_B = 17'd42334;
    localparam logic [16:0] SIN_C = 17'd5223;
    localparam logic [16:0] SIN_D = 17'd307;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PARALLEL_WEIGHT   = 3'd0,
        REG_ORTHOGONAL_WEIGHT = 3'd1,
        REG_HEADING_WEIGHT    = 3'd2,
        REG_AREA_WEIGHT       = 3'd3,
        REG_IMAGE_SIZE        = 3'd4,
        REG_ACCEPT_THRESHOLD  = 3'd5
    } cfg_reg_t;

    typedef logic signed [TRIG_W-1:0] trig_t;

endpackage

`default_nettype wire

FILE: rtl/ppms_delay.sv
`default_nettype none

module ppms_delay #(
    parameter int unsigned W = 1,
    parameter int unsigned D = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [D];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < int'(D); i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[D-1];

endmodule

`default_nettype wire

FILE: rtl/ppms_sine.sv
`default_nettype none

module ppms_sine (
    input  logic                  clk,
    input  logic                  en,
    input  logic [15:0]           angle,
    output ppms_pkg::trig_t       sin_val,
    output ppms_pkg::trig_t       cos_val
);
    import ppms_pkg::*;

    trig_t res_reg [2];

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic [15:0] ang;
        logic [16:0] x_in;
        logic [16:0] x_reg  [5];
        logic        neg_reg [5];
        logic [16:0] x2_reg [3];
        logic [12:0] t1_reg;
        logic [15:0] t2_reg;
        logic [16:0] t3_reg;
        logic [33:0] sq, p1, p2, p3, p4;
        logic [17:0] r;
        logic [16:0] rc;

        assign ang  = (l == 0) ? angle : angle + 16'd16384;
        assign x_in = ang[14] ? (17'd65536 - 17'({ang[13:0], 2'b00}))
                              : 17'({ang[13:0], 2'b00});

        assign sq = 34'(x_reg[0]) * 34'(x_reg[0]);
        assign p1 = 34'(x2_reg[0]) * 34'(SIN_D);
        assign p2 = 34'(x2_reg[1]) * 34'(t1_reg);
        assign p3 = 34'(x2_reg[2]) * 34'(t2_reg);
        assign p4 = 34'(x_reg[4]) * 34'(t3_reg);
        assign r  = p4[33:16];
        assign rc = (r > 18'd65536) ? 17'd65536 : r[16:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[0]   <= x_in;
                neg_reg[0] <= ang[15];
                for (int i = 1; i < 5; i++)
                begin
                    x_reg[i]   <= x_reg[i-1];
                    neg_reg[i] <= neg_reg[i-1];
                end
                x2_reg[0] <= sq[32:16];
                x2_reg[1] <= x2_reg[0];
                x2_reg[2] <= x2_reg[1];
                t1_reg    <= 13'(SIN_C - p1[32:16]);
                t2_reg    <= 16'(SIN_B - p2[32:16]);
                t3_reg    <= SIN_A - p3[32:16];
                res_reg[l] <= neg_reg[4] ? -trig_t'({1'b0, rc}) : trig_t'({1'b0, rc});
            end
        end
    end

    assign sin_val = res_reg[0];
    assign cos_val = res_reg[1];

endmodule

`default_nettype wire

FILE: rtl/ppms_div.sv
`default_nettype none

module ppms_div #(
    parameter int unsigned NUM_W = 56,
    parameter int unsigned DEN_W = 32,
    parameter int unsigned QW    = ppms_pkg::QUO_W
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [QW-1:0]    quo
);

    logic [DEN_W-1:0] rem_reg [QW];
    logic [QW-1:0]    low_reg [QW];
    logic [DEN_W-1:0] den_reg [QW];
    logic [QW-1:0]    quo_reg [QW];

    for (genvar i = 0; i < QW; i++)
    begin : g_step
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QW-1:0]    low_in;
        logic [QW-1:0]    quo_in;
        logic [DEN_W:0]   trial;
        logic             take;

        if (i == 0)
        begin : g_first
            assign rem_in = DEN_W'(num[NUM_W-1:QW]);
            assign low_in = num[QW-1:0];
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign den_in = den_reg[i-1];
            assign quo_in = quo_reg[i-1];
        end

        // one quotient bit per stage
        assign trial = {rem_in, low_in[QW-1]};
        assign take  = trial >= {1'b0, den_in};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
                low_reg[i] <= low_in << 1;
                den_reg[i] <= den_in;
                quo_reg[i] <= {quo_in[QW-2:0], take};
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

`default_nettype wire

FILE: rtl/particle_pair_match_score.sv
// particle pair match score
// input channel in_valid / in_ready carries one request: two particles, each
// with position, heading, box width and height. output channel out_valid /
// out_ready returns match_cost (q8.16, saturating) and within_threshold.
// registers are written through cfg_we / cfg_index / cfg_data; the user
// must write them only while no request is in flight, as the block itself
// does not enforce this. unknown indexes are dropped. one request is taken
// every cycle while the output is not stalled; the pipeline depth is set by
// the distance path: heading quantization (3), sine polynomial pipeline (6),
// projections and weighting (5), a 24-stage restoring divider and the
// output register. the area divider runs alongside and is delayed to match.
// the whole pipeline advances together: when out_valid is high and out_ready
// is low every stage holds and in_ready drops, so nothing is lost or repeated.
// reset clears the stage valid bits and loads the register defaults; no
// result is shown until a request has gone through.
`default_nettype none

module particle_pair_match_score #(
    parameter int unsigned TRIG_TABLE_ENTRIES = ppms_pkg::TRIG_ENTRIES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ppms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ppms_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [ppms_pkg::FIELD_W-1:0]      first_pos_x,
    input  logic [ppms_pkg::FIELD_W-1:0]      first_pos_y,
    input  logic [ppms_pkg::FIELD_W-1:0]      first_heading,
    input  logic [ppms_pkg::FIELD_W-1:0]      first_width,
    input  logic [ppms_pkg::FIELD_W-1:0]      first_height,
    input  logic [ppms_pkg::FIELD_W-1:0]      second_pos_x,
    input  logic [ppms_pkg::FIELD_W-1:0]      second_pos_y,
    input  logic [ppms_pkg::FIELD_W-1:0]      second_heading,
    input  logic [ppms_pkg::FIELD_W-1:0]      second_width,
    input  logic [ppms_pkg::FIELD_W-1:0]      second_height,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ppms_pkg::COST_W-1:0]       match_cost,
    output logic                              within_threshold
);
    import ppms_pkg::*;

    localparam int unsigned IDX_W     = $clog2(TRIG_TABLE_ENTRIES);
    localparam logic [32:0] TRIG_N    = 33'(TRIG_TABLE_ENTRIES);
    localparam logic [32:0] RECIP     = 33'((64'd1 << 32) / 64'(TRIG_TABLE_ENTRIES));
    localparam int unsigned ST_HEAD_Q = 3;
    localparam int unsigned ST_TRIG   = ST_HEAD_Q + SINE_LAT;
    localparam int unsigned ST_DNUM   = ST_TRIG + 5;
    localparam int unsigned ST_QUO    = ST_DNUM + QUO_W;
    localparam int unsigned ST_AREA_Q = ST_HEAD_Q + QUO_W;
    localparam int unsigned LAT       = ST_QUO + 1;

    // configuration registers
    logic [FIELD_W-1:0] par_w_reg, orth_w_reg, head_w_reg, area_w_reg, size_reg;
    logic [COST_W-1:0]  thr_reg;
    logic [FIELD_W-1:0] size_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_w_reg  <= PAR_W_RST;
            orth_w_reg <= ORTH_W_RST;
            head_w_reg <= HEAD_W_RST;
            area_w_reg <= AREA_W_RST;
            size_reg   <= SIZE_RST;
            thr_reg    <= THR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PARALLEL_WEIGHT:   par_w_reg  <= cfg_data[FIELD_W-1:0];
                REG_ORTHOGONAL_WEIGHT: orth_w_reg <= cfg_data[FIELD_W-1:0];
                REG_HEADING_WEIGHT:    head_w_reg <= cfg_data[FIELD_W-1:0];
                REG_AREA_WEIGHT:       area_w_reg <= cfg_data[FIELD_W-1:0];
                REG_IMAGE_SIZE:        size_reg   <= cfg_data[FIELD_W-1:0];
                REG_ACCEPT_THRESHOLD:  thr_reg    <= cfg_data[COST_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign size_eff = (size_reg == '0) ? 16'd1 : size_reg;

    // stage valid bits, global advance
    logic           adv;
    logic [LAT-1:0] vld_reg;

    assign adv       = out_ready || !vld_reg[LAT-1];
    assign in_ready  = adv;
    assign out_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_valid};
        end
    end

    // stage 1: deltas, heading index, heading term, areas
    logic signed [16:0] dx_next, dy_next, dx_reg, dy_reg;
    logic [14:0]        hdiff;
    logic [15:0]        hdiff_ext, hcomp, hmin;
    logic [31:0]        hprod;
    logic [COST_W-1:0]  hterm_reg;
    logic [31:0]        ar1_reg, ar2_reg;

    assign dx_next   = $signed({1'b0, second_pos_x}) - $signed({1'b0, first_pos_x});
    assign dy_next   = $signed({1'b0, second_pos_y}) - $signed({1'b0, first_pos_y});
    assign hdiff     = 15'(first_heading - second_heading);
    assign hdiff_ext = {1'b0, hdiff};
    assign hcomp     = 16'd32768 - hdiff_ext;
    assign hmin      = (hdiff_ext < hcomp) ? hdiff_ext : hcomp;
    assign hprod     = 32'(head_w_reg) * 32'(hmin);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            hterm_reg <= hprod[29:6];
            ar1_reg   <= 32'(first_width) * 32'(first_height);
            ar2_reg   <= 32'(second_width) * 32'(second_height);
        end
    end

    // stages 1..3: heading quantization, one lane per particle
    logic [FIELD_W-1:0] head_in [2];
    logic [FIELD_W-1:0] q_reg   [2];

    assign head_in[0] = first_heading;
    assign head_in[1] = second_heading;

    for (genvar j = 0; j < 2; j++)
    begin : g_quant
        logic [32:0]        hp, qp, qn, rm;
        logic [IDX_W-1:0]   idx_reg, idx2_reg;
        logic [FIELD_W-1:0] qa_reg;

        assign hp = 33'(head_in[j]) * TRIG_N;
        assign qp = 33'(idx_reg) * RECIP;
        assign qn = 33'(qa_reg) * TRIG_N;
        assign rm = (33'(idx2_reg) << 16) - qn;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                idx_reg  <= hp[16 +: IDX_W];
                idx2_reg <= idx_reg;
                qa_reg   <= qp[31:16];
                q_reg[j] <= (rm >= TRIG_N) ? qa_reg + 16'd1 : qa_reg;
            end
        end
    end

    // stages 2..3: area numerator and denominator
    logic [31:0] abig_reg, adiff_reg, aden_reg;
    logic [55:0] anum_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            abig_reg  <= (ar1_reg >= ar2_reg) ? ar1_reg : ar2_reg;
            adiff_reg <= (ar1_reg >= ar2_reg) ? ar1_reg - ar2_reg : ar2_reg - ar1_reg;
            anum_reg  <= {48'(area_w_reg) * 48'(adiff_reg), 8'd0};
            aden_reg  <= (abig_reg == '0) ? 32'd1 : abig_reg;
        end
    end

    logic [QUO_W-1:0] aterm, aterm_d;

    ppms_div #(
        .NUM_W (56),
        .DEN_W (32),
        .QW    (QUO_W)
    ) u_div_area (
        .clk (clk),
        .en  (adv),
        .num (anum_reg),
        .den (aden_reg),
        .quo (aterm)
    );

    ppms_delay #(
        .W (QUO_W),
        .D (ST_QUO - ST_AREA_Q)
    ) u_dly_area (
        .clk  (clk),
        .en   (adv),
        .din  (aterm),
        .dout (aterm_d)
    );

    // sine and cosine of both headings
    trig_t sn [2];
    trig_t cs [2];

    for (genvar j = 0; j < 2; j++)
    begin : g_trig
        ppms_sine u_sine (
            .clk     (clk),
            .en      (adv),
            .angle   (q_reg[j]),
            .sin_val (sn[j]),
            .cos_val (cs[j])
        );
    end

    logic signed [16:0] dx_d, dy_d;

    ppms_delay #(
        .W (34),
        .D (ST_TRIG - 1)
    ) u_dly_dxy (
        .clk  (clk),
        .en   (adv),
        .din  ({dx_reg, dy_reg}),
        .dout ({dx_d, dy_d})
    );

    // projections onto each heading
    logic [34:0] p_reg [2];
    logic [34:0] o_reg [2];

    for (genvar j = 0; j < 2; j++)
    begin : g_proj
        logic signed [34:0] dxc_reg, dys_reg, dxs_reg, dyc_reg;
        logic signed [35:0] psum, osum;

        assign psum = 36'(dxc_reg) + 36'(dys_reg);
        assign osum = 36'(dxs_reg) - 36'(dyc_reg);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dxc_reg  <= 35'(dx_d) * 35'(cs[j]);
                dys_reg  <= 35'(dy_d) * 35'(sn[j]);
                dxs_reg  <= 35'(dx_d) * 35'(sn[j]);
                dyc_reg  <= 35'(dy_d) * 35'(cs[j]);
                p_reg[j] <= psum[35] ? 35'(-psum) : 35'(psum);
                o_reg[j] <= osum[35] ? 35'(-osum) : 35'(osum);
            end
        end
    end

    // distance sums, weighting, overflow check
    logic [35:0] para_reg, orth_reg;
    logic [51:0] wpar_reg, worth_reg;
    logic [36:0] dnum_p_reg, dnum_o_reg;
    logic        ovf_p_reg, ovf_o_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            para_reg   <= 36'(p_reg[0]) + 36'(p_reg[1]);
            orth_reg   <= 36'(o_reg[0]) + 36'(o_reg[1]);
            wpar_reg   <= 52'(par_w_reg) * 52'(para_reg);
            worth_reg  <= 52'(orth_w_reg) * 52'(orth_reg);
            dnum_p_reg <= wpar_reg[51:15];
            dnum_o_reg <= worth_reg[51:15];
            ovf_p_reg  <= {3'b000, wpar_reg[51:39]} >= size_eff;
            ovf_o_reg  <= {3'b000, worth_reg[51:39]} >= size_eff;
        end
    end

    logic [QUO_W-1:0] pterm, oterm;

    ppms_div #(
        .NUM_W (37),
        .DEN_W (FIELD_W),
        .QW    (QUO_W)
    ) u_div_par (
        .clk (clk),
        .en  (adv),
        .num (dnum_p_reg),
        .den (size_eff),
        .quo (pterm)
    );

    ppms_div #(
        .NUM_W (37),
        .DEN_W (FIELD_W),
        .QW    (QUO_W)
    ) u_div_orth (
        .clk (clk),
        .en  (adv),
        .num (dnum_o_reg),
        .den (size_eff),
        .quo (oterm)
    );

    logic [1:0]        ovf_d;
    logic [COST_W-1:0] hterm_d;

    ppms_delay #(
        .W (2),
        .D (ST_QUO - ST_DNUM)
    ) u_dly_ovf (
        .clk  (clk),
        .en   (adv),
        .din  ({ovf_p_reg, ovf_o_reg}),
        .dout (ovf_d)
    );

    ppms_delay #(
        .W (COST_W),
        .D (ST_QUO - 1)
    ) u_dly_head (
        .clk  (clk),
        .en   (adv),
        .din  (hterm_reg),
        .dout (hterm_d)
    );

    // final sum and saturation
    logic [COST_W+1:0] total;
    logic [COST_W-1:0] cost_next;
    logic [COST_W-1:0] cost_reg;
    logic              within_reg;

    assign total     = (COST_W+2)'(pterm) + (COST_W+2)'(oterm)
                     + (COST_W+2)'(hterm_d) + (COST_W+2)'(aterm_d);
    assign cost_next = ((ovf_d != 2'b00) || (total > (COST_W+2)'(COST_MAX)))
                     ? COST_MAX : total[COST_W-1:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cost_reg   <= cost_next;
            within_reg <= cost_next <= thr_reg;
        end
    end

    assign match_cost       = cost_reg;
    assign within_threshold = within_reg;

endmodule

`default_nettype wire

FILE: rtl/ppms_checker.sv
`default_nettype none

`include "particle_pair_match_score_defines.svh"

module ppms_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              cfg_we,
    input logic [ppms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input logic [ppms_pkg::CFG_DATA_W-1:0]   cfg_data,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [ppms_pkg::COST_W-1:0]       match_cost,
    input logic                              within_threshold
);
    import ppms_pkg::*;

    logic [COST_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RST;
        end
        else if (cfg_we && (cfg_index == REG_ACCEPT_THRESHOLD))
        begin
            thr_reg <= cfg_data[COST_W-1:0];
        end
    end

    `PPMS_ASSERT_NEXT(a_result_held, out_valid && !out_ready,
        out_valid && $stable(match_cost) && $stable(within_threshold),
        "result changed while stalled")
    `PPMS_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready,
        "request refused with empty output")
    `PPMS_ASSERT_NOW(a_threshold_flag, out_valid,
        within_threshold == (match_cost <= thr_reg),
        "threshold flag disagrees with cost")

endmodule

bind particle_pair_match_score ppms_checker u_ppms_checker (.*);

`default_nettype wire
